### rtl/length_prefixed_block_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_BLOCK_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_BLOCK_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPBD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LPBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer next-cycle check failed");

`endif

### rtl/lpbd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Phase type, result status codes and register constants for the deframer.
// ----------------------------------------------------------------------------
package lpbd_pkg;

   typedef enum logic [1:0] {
      PH_PREFIX  = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_ERROR   = 2'd3
   } phase_type;

   typedef logic [1:0] status_type;

   localparam status_type ST_PAYLOAD = 2'd0;
   localparam status_type ST_EMPTY   = 2'd1;
   localparam status_type ST_SHORT   = 2'd2;
   localparam status_type ST_LEN_ERR = 2'd3;

   localparam logic [1:0]  LAST_COUNT        = 2'd3;
   localparam logic [1:0]  ADDR_MAX_BLOCK_LEN = 2'd0;
   localparam logic [31:0] MAX_BLOCK_LEN_RESET = 32'd16777216;

endpackage

### rtl/length_prefixed_block_deframer_unit.sv
// ----------------------------------------------------------------------------
// Length-prefixed block deframer
// Splits a byte stream into blocks with a four-byte big-endian length prefix
// and a four-byte inner header, emitting one result per payload byte or a status.
// ----------------------------------------------------------------------------
// One byte enters per cycle and its result, if any, shows on the rsp_ side in
// the next cycle from a single result register. The only thing that slows the
// input is that register: req_stall is high while it holds a beat that the
// receiver stalls, so the sustained rate is one byte per cycle whenever the
// receiver takes results. A body length above max_block_len gives one
// length-error result, after which all bytes are taken and dropped until reset.
`include "length_prefixed_block_deframer_unit_macros.svh"

module length_prefixed_block_deframer_unit (
   input  logic                    clock,
   input  logic                    reset,
   // byte input
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   // result output
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output lpbd_pkg::status_type    rsp_status,
   output logic [7:0]              rsp_payload_byte,
   output logic [7:0]              rsp_msg_type,
   output logic [7:0]              rsp_msg_flags,
   output logic [15:0]             rsp_channel,
   output logic [31:0]             rsp_block_len,
   output logic                    rsp_last,
   // register port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [1:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   import lpbd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  byte_count_ff, byte_count_in;
   logic [31:0] length_shift_ff, length_shift_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [7:0]  held_flags_ff, held_flags_in;
   logic [15:0] held_channel_ff, held_channel_in;
   logic [31:0] max_block_len_ff, max_block_len_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_payload_ff, rsp_payload_in;
   logic [7:0]  rsp_type_ff, rsp_type_in;
   logic [7:0]  rsp_flags_ff, rsp_flags_in;
   logic [15:0] rsp_channel_ff, rsp_channel_in;
   logic [31:0] rsp_block_len_ff, rsp_block_len_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        take;
   logic        emit;
   logic        count_end;
   logic        rem_last;
   logic [31:0] shift_next;
   logic [31:0] rem_dec;
   logic        cfg_write;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign take       = req_valid & ~req_stall;
   assign count_end  = (byte_count_ff == LAST_COUNT);
   assign shift_next = {length_shift_ff[23:0], req_data_byte};
   assign rem_dec    = remaining_ff - 32'd1;
   assign rem_last   = (rem_dec == 32'd0);

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & (paddr == ADDR_MAX_BLOCK_LEN);
   assign prdata    = (paddr == ADDR_MAX_BLOCK_LEN) ? max_block_len_ff : 32'd0;
   assign max_block_len_in = cfg_write ? pwdata : max_block_len_ff;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PH_PREFIX: begin
               if (count_end) begin
                  if (shift_next > max_block_len_ff) begin
                     phase_in = PH_ERROR;
                  end else if (shift_next != 32'd0) begin
                     phase_in = PH_HEADER;
                  end
               end
            end
            PH_HEADER: begin
               if (rem_last) begin
                  phase_in = PH_PREFIX;
               end else if (count_end) begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (rem_last) begin
                  phase_in = PH_PREFIX;
               end
            end
            PH_ERROR: begin
               phase_in = PH_ERROR;
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

   // Datapath and result
   always_comb begin
      byte_count_in    = byte_count_ff;
      length_shift_in  = length_shift_ff;
      remaining_in     = remaining_ff;
      held_type_in     = held_type_ff;
      held_flags_in    = held_flags_ff;
      held_channel_in  = held_channel_ff;
      emit             = 1'b0;
      rsp_status_in    = ST_PAYLOAD;
      rsp_payload_in   = 8'd0;
      rsp_type_in      = 8'd0;
      rsp_flags_in     = 8'd0;
      rsp_channel_in   = 16'd0;
      rsp_block_len_in = length_shift_ff;
      rsp_last_in      = 1'b1;
      if (take) begin
         unique case (phase_ff)
            PH_PREFIX: begin
               length_shift_in  = shift_next;
               rsp_block_len_in = shift_next;
               byte_count_in    = byte_count_ff + 2'd1;
               if (count_end) begin
                  if (shift_next > max_block_len_ff) begin
                     emit          = 1'b1;
                     rsp_status_in = ST_LEN_ERR;
                  end else if (shift_next == 32'd0) begin
                     emit          = 1'b1;
                     rsp_status_in = ST_SHORT;
                  end else begin
                     remaining_in    = shift_next;
                     held_type_in    = 8'd0;
                     held_flags_in   = 8'd0;
                     held_channel_in = 16'd0;
                  end
               end
            end
            PH_HEADER: begin
               case (byte_count_ff)
                  2'd0:    held_type_in    = req_data_byte;
                  2'd1:    held_flags_in   = req_data_byte;
                  default: held_channel_in = {held_channel_ff[7:0], req_data_byte};
               endcase
               remaining_in  = rem_dec;
               byte_count_in = byte_count_ff + 2'd1;
               if (rem_last) begin
                  byte_count_in = 2'd0;
                  emit          = 1'b1;
                  if (count_end) begin
                     rsp_status_in  = ST_EMPTY;
                     rsp_type_in    = held_type_ff;
                     rsp_flags_in   = held_flags_ff;
                     rsp_channel_in = {held_channel_ff[7:0], req_data_byte};
                  end else begin
                     rsp_status_in = ST_SHORT;
                  end
               end
            end
            PH_PAYLOAD: begin
               remaining_in   = rem_dec;
               emit           = 1'b1;
               rsp_status_in  = ST_PAYLOAD;
               rsp_payload_in = req_data_byte;
               rsp_type_in    = held_type_ff;
               rsp_flags_in   = held_flags_ff;
               rsp_channel_in = held_channel_ff;
               rsp_last_in    = rem_last;
            end
            default: begin
               // drop silently
               emit = 1'b0;
            end
         endcase
      end
      rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_PREFIX;
         byte_count_ff    <= 2'd0;
         length_shift_ff  <= 32'd0;
         remaining_ff     <= 32'd0;
         held_type_ff     <= 8'd0;
         held_flags_ff    <= 8'd0;
         held_channel_ff  <= 16'd0;
         max_block_len_ff <= MAX_BLOCK_LEN_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         byte_count_ff    <= byte_count_in;
         length_shift_ff  <= length_shift_in;
         remaining_ff     <= remaining_in;
         held_type_ff     <= held_type_in;
         held_flags_ff    <= held_flags_in;
         held_channel_ff  <= held_channel_in;
         max_block_len_ff <= max_block_len_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Load the result beat only when a new one is produced
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_payload_ff   <= rsp_payload_in;
         rsp_type_ff      <= rsp_type_in;
         rsp_flags_ff     <= rsp_flags_in;
         rsp_channel_ff   <= rsp_channel_in;
         rsp_block_len_ff <= rsp_block_len_in;
         rsp_last_ff      <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_payload_byte = rsp_payload_ff;
   assign rsp_msg_type     = rsp_type_ff;
   assign rsp_msg_flags    = rsp_flags_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_block_len    = rsp_block_len_ff;
   assign rsp_last         = rsp_last_ff;

   `LPBD_ASSERT_NEXT(a_error_silent, clock, reset,
      (phase_ff == PH_ERROR) && !rsp_valid_ff, !rsp_valid_ff)
   `LPBD_ASSERT_NEXT(a_payload_gives_beat, clock, reset,
      take && (phase_ff == PH_PAYLOAD), rsp_valid_ff && (rsp_status_ff == ST_PAYLOAD))
   `LPBD_ASSERT_SAME(a_status_implies_last, clock, reset,
      rsp_valid_ff && (rsp_status_ff != ST_PAYLOAD), rsp_last_ff)
   `LPBD_ASSERT_SAME(a_count_phase, clock, reset,
      byte_count_ff != 2'd0, (phase_ff == PH_PREFIX) || (phase_ff == PH_HEADER))

endmodule
